// File: hw/rtl/damper_throw_alternator_macros.svh
// Assertion macros for the damper throw alternator.
// Used by the top level; no other dependencies.
`ifndef DAMPER_THROW_ALTERNATOR_MACROS_SVH
`define DAMPER_THROW_ALTERNATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTA_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("damper_throw_alternator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DTA_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("damper_throw_alternator: next-cycle check failed");

`endif

// File: hw/rtl/dta_pkg.sv
// Shared types and constants for the damper throw alternator.
// No dependencies; imported by every module of the block.
package dta_pkg;

   localparam int TIMER_WIDTH    = 16;
   localparam int DWELL_WIDTH    = 16;
   localparam int CMP_WIDTH      = (TIMER_WIDTH > DWELL_WIDTH) ? TIMER_WIDTH : DWELL_WIDTH;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REG_INDEX_BIT  = 2;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 8;

   localparam logic [TIMER_WIDTH-1:0] COUNT_MAX = {TIMER_WIDTH{1'b1}};

   // Operating mode codes; the fourth code behaves like standby.
   localparam logic [1:0] MODE_INIT    = 2'd0;
   localparam logic [1:0] MODE_RUN     = 2'd1;
   localparam logic [1:0] MODE_STANDBY = 2'd2;

   // Register indexes, selected by one address bit.
   localparam logic REG_HIGH_DWELL = 1'b0;
   localparam logic REG_LOW_DWELL  = 1'b1;

   typedef enum logic [2:0] {
      PH_INIT    = 3'd0,
      PH_HIGH    = 3'd1,
      PH_TO_LOW  = 3'd2,
      PH_LOW     = 3'd3,
      PH_TO_HIGH = 3'd4
   } dta_phase_type;

   typedef struct packed {
      logic high_open;
      logic high_close;
      logic low_open;
      logic low_close;
   } dta_req_type;

   // Request patterns for the two throw positions.
   localparam dta_req_type REQ_HIGH_THROW = '{high_open: 1'b1, high_close: 1'b0,
                                              low_open: 1'b0, low_close: 1'b1};
   localparam dta_req_type REQ_LOW_THROW  = '{high_open: 1'b0, high_close: 1'b1,
                                              low_open: 1'b1, low_close: 1'b0};

   typedef struct packed {
      logic [1:0]  operating_mode;
      logic        run_enable;
      logic        second_tick;
      dta_req_type done;
   } dta_item_type;

   typedef struct packed {
      dta_phase_type          phase;
      logic [TIMER_WIDTH-1:0] high_count;
      logic [TIMER_WIDTH-1:0] low_count;
      dta_req_type            req;
   } dta_state_type;

   typedef struct packed {
      logic [DWELL_WIDTH-1:0] high_dwell_seconds;
      logic [DWELL_WIDTH-1:0] low_dwell_seconds;
   } dta_cfg_type;

endpackage

// File: hw/rtl/damper_throw_alternator.sv
// Top level of the damper throw alternator: stream channels, state and result registers.
// Depends on dta_pkg, dta_csr, dta_step and damper_throw_alternator_macros.svh.
//
//   Channel   Direction  Handshake                    Payload
//   req_*     in         req_tvalid / req_tready      req_tdata, 8 bits, update item
//   rsp_*     out        rsp_tvalid / rsp_tready      rsp_tdata, 8 bits, phase and requests
//   csr_*     in/out     psel, penable, pready = 1    two 16-bit dwell setpoints
//
// Every accepted transaction yields exactly one result transaction.
// From acceptance a transaction passes the input register, then the result register, which drives rsp_tvalid;
// one transaction per cycle is sustained while rsp_tready is high,
// set by the combinational state update between the input register and the result register.
// The input register keeps taking transactions while the result register drains; it stalls
// only when both are full and rsp_tready is low.
// Synchronous active-high reset empties both registers, zeroes the phase, counters and
// request flags, and clears both setpoints.
module damper_throw_alternator (
   input  logic                                clock,
   input  logic                                reset,
   // Update items.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [1:0] operating_mode, [2] run_enable, [3] second_tick, [4] high_open_done,
   // [5] high_close_done, [6] low_open_done, [7] low_close_done
   input  logic [dta_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // Results.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] phase_status, [3] high_open_request, [4] high_close_request,
   // [5] low_open_request, [6] low_close_request, [7] zero
   output logic [dta_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // Configuration.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dta_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [dta_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [dta_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import dta_pkg::*;

   `include "damper_throw_alternator_macros.svh"

   dta_cfg_type                cfg;
   dta_item_type               item_ff;
   dta_item_type               item_in;
   logic                       in_valid_ff;
   logic                       out_valid_ff;
   logic [RSP_DATA_WIDTH-1:0]  rsp_data_ff;
   logic [RSP_DATA_WIDTH-1:0]  rsp_data_in;
   dta_state_type              state_ff;
   dta_state_type              state_in;
   logic                       advance;
   logic                       accept;

   dta_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Unpack the incoming transaction; field order follows the tdata layout.
   assign item_in.operating_mode  = req_tdata[1:0];
   assign item_in.run_enable      = req_tdata[2];
   assign item_in.second_tick     = req_tdata[3];
   assign item_in.done.high_open  = req_tdata[4];
   assign item_in.done.high_close = req_tdata[5];
   assign item_in.done.low_open   = req_tdata[6];
   assign item_in.done.low_close  = req_tdata[7];

   // The held item moves into the result register whenever that register is free
   // or is being emptied in this cycle. The state is committed at the same edge,
   // so the next held item always sees the state left by its predecessor.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   dta_step u_step (
      .item (item_ff),
      .cur  (state_ff),
      .cfg  (cfg),
      .nxt  (state_in)
   );

   // The result reports the state after the update.
   assign rsp_data_in = {1'b0,
                         state_in.req.low_close,
                         state_in.req.low_open,
                         state_in.req.high_close,
                         state_in.req.high_open,
                         state_in.phase};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         state_ff.phase     <= PH_INIT;
         state_ff.high_count <= '0;
         state_ff.low_count <= '0;
         state_ff.req       <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The block empties completely on reset.
   `DTA_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
   // A full input register behind a stalled result cannot take a new transaction.
   `DTA_ASSERT_SAME(a_stall_backpressure, clock, reset,
                    in_valid_ff && rsp_tvalid && !rsp_tready, !req_tready)
   // Every advance produces a result in the next cycle.
   `DTA_ASSERT_NEXT(a_advance_result, clock, reset, advance, rsp_tvalid)
   // The state only moves when a transaction is processed.
   `DTA_ASSERT_NEXT(a_state_hold, clock, reset, !advance, $stable(state_ff))

endmodule

// File: hw/rtl/dta_csr.sv
// Configuration register file for the damper throw alternator.
// Depends on dta_pkg for widths and register indexes.
module dta_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dta_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [dta_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [dta_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   output dta_pkg::dta_cfg_type                cfg
);
   import dta_pkg::*;

   logic [DWELL_WIDTH-1:0] high_dwell_ff;
   logic [DWELL_WIDTH-1:0] low_dwell_ff;
   logic                   write_en;
   logic                   reg_sel;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[REG_INDEX_BIT];

   always_ff @(posedge clock) begin
      if (reset) begin
         high_dwell_ff <= '0;
         low_dwell_ff  <= '0;
      end else if (write_en) begin
         unique case (reg_sel)
            REG_HIGH_DWELL: high_dwell_ff <= csr_pwdata[DWELL_WIDTH-1:0];
            REG_LOW_DWELL:  low_dwell_ff  <= csr_pwdata[DWELL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_HIGH_DWELL:
            csr_prdata = {{(CSR_DATA_WIDTH-DWELL_WIDTH){1'b0}}, high_dwell_ff};
         REG_LOW_DWELL:
            csr_prdata = {{(CSR_DATA_WIDTH-DWELL_WIDTH){1'b0}}, low_dwell_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   assign cfg.high_dwell_seconds = high_dwell_ff;
   assign cfg.low_dwell_seconds  = low_dwell_ff;

endmodule

// File: hw/rtl/dta_step.sv
// Next-state logic for one update transaction of the damper throw alternator.
// Depends on dta_pkg for the item, state and configuration types.
module dta_step (
   input  dta_pkg::dta_item_type  item,
   input  dta_pkg::dta_state_type cur,
   input  dta_pkg::dta_cfg_type   cfg,
   output dta_pkg::dta_state_type nxt
);
   import dta_pkg::*;

   logic [TIMER_WIDTH-1:0] high_up;
   logic [TIMER_WIDTH-1:0] low_up;
   logic                   high_end;
   logic                   low_end;
   dta_req_type            req_cleared;

   // Dwell counters saturate at their all-ones value.
   assign high_up = (item.second_tick && cur.high_count != COUNT_MAX)
                    ? cur.high_count + 1'b1 : cur.high_count;
   assign low_up  = (item.second_tick && cur.low_count != COUNT_MAX)
                    ? cur.low_count + 1'b1 : cur.low_count;

   // A zero setpoint never ends the phase.
   assign high_end = (cfg.high_dwell_seconds != '0) &&
                     (CMP_WIDTH'(high_up) >= CMP_WIDTH'(cfg.high_dwell_seconds));
   assign low_end  = (cfg.low_dwell_seconds != '0) &&
                     (CMP_WIDTH'(low_up) >= CMP_WIDTH'(cfg.low_dwell_seconds));

   // Done strobes clear their request before anything else happens.
   assign req_cleared = cur.req & ~item.done;

   always_comb begin
      nxt     = cur;
      nxt.req = req_cleared;
      case (item.operating_mode)
         MODE_INIT: begin
            nxt.phase      = PH_INIT;
            nxt.high_count = '0;
            nxt.low_count  = '0;
            nxt.req        = REQ_HIGH_THROW;
         end
         MODE_RUN: begin
            if (item.run_enable) begin
               unique case (cur.phase)
                  PH_INIT: begin
                     nxt.req   = REQ_HIGH_THROW;
                     nxt.phase = PH_HIGH;
                  end
                  PH_HIGH: begin
                     if (high_end) begin
                        nxt.high_count = '0;
                        nxt.req        = REQ_LOW_THROW;
                        nxt.phase      = PH_TO_LOW;
                     end else begin
                        nxt.high_count = high_up;
                     end
                  end
                  PH_TO_LOW: begin
                     if (!req_cleared.high_close && !req_cleared.low_open) begin
                        nxt.phase = PH_LOW;
                     end
                  end
                  PH_LOW: begin
                     if (low_end) begin
                        nxt.low_count = '0;
                        nxt.req       = REQ_HIGH_THROW;
                        nxt.phase     = PH_TO_HIGH;
                     end else begin
                        nxt.low_count = low_up;
                     end
                  end
                  PH_TO_HIGH: begin
                     if (!req_cleared.low_close && !req_cleared.high_open) begin
                        nxt.phase = PH_HIGH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

endmodule
